// ===== rtl/ipv6_frame_drop_and_header_extract_core_macros.svh =====
// assertion macros for the ipv6 frame drop and header extract core
`ifndef IPV6_FRAME_DROP_AND_HEADER_EXTRACT_CORE_MACROS_SVH
`define IPV6_FRAME_DROP_AND_HEADER_EXTRACT_CORE_MACROS_SVH

`ifndef SYNTHESIS

`define IPV6FD_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define IPV6FD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define IPV6FD_ASSERT(label, clk, rst_n, prop, msg)

`define IPV6FD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== rtl/ipv6fd_pkg.sv =====
// shared types and constants for the ipv6 frame drop and header extract core
package ipv6fd_pkg;

    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 352;

    localparam logic [15:0] ETHERTYPE_IPV6 = 16'h86DD;
    localparam logic [7:0]  PROTO_TCP      = 8'd6;
    localparam logic [7:0]  PROTO_UDP      = 8'd17;
    localparam logic [6:0]  OFFSET_MAX     = 7'd127;

    localparam logic [6:0]  POS_META       = 7'd0;
    localparam logic [6:0]  POS_ETYPE_HI   = 7'd12;
    localparam logic [6:0]  POS_ETYPE_LO   = 7'd13;
    localparam logic [6:0]  POS_PLEN_HI    = 7'd18;
    localparam logic [6:0]  POS_PLEN_LO    = 7'd19;
    localparam logic [6:0]  POS_NEXT_HDR   = 7'd20;
    localparam logic [6:0]  POS_SRC_HI_LO  = 7'd22;
    localparam logic [6:0]  POS_SRC_HI_HI  = 7'd29;
    localparam logic [6:0]  POS_SRC_LO_LO  = 7'd30;
    localparam logic [6:0]  POS_SRC_LO_HI  = 7'd37;
    localparam logic [6:0]  POS_DST_HI_LO  = 7'd38;
    localparam logic [6:0]  POS_DST_HI_HI  = 7'd45;
    localparam logic [6:0]  POS_DST_LO_LO  = 7'd46;
    localparam logic [6:0]  POS_DST_LO_HI  = 7'd53;
    localparam logic [6:0]  POS_SPORT_HI   = 7'd54;
    localparam logic [6:0]  POS_SPORT_LO   = 7'd55;
    localparam logic [6:0]  POS_DPORT_HI   = 7'd56;
    localparam logic [6:0]  POS_DPORT_LO   = 7'd57;

    localparam logic [7:0]  LEN_ETH_HDR    = 8'd14;
    localparam logic [7:0]  LEN_IP6_END    = 8'd54;
    localparam logic [7:0]  LEN_TCP_END    = 8'd74;
    localparam logic [7:0]  LEN_UDP_END    = 8'd62;

    typedef struct packed {
        logic        is_egress;
        logic [31:0] port_index;
        logic [7:0]  frame_byte;
    } beat_t;

    typedef struct packed {
        logic        report_egress;
        logic [31:0] report_port_index;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic [15:0] payload_bytes;
        logic [63:0] dest_low;
        logic [63:0] dest_high;
        logic [63:0] source_low;
        logic [63:0] source_high;
        logic [7:0]  next_header;
        logic        drop_frame;
    } result_t;

endpackage

// ===== rtl/ipv6fd_parse.sv =====
// byte position tracking, header field capture and verdict logic
`include "ipv6_frame_drop_and_header_extract_core_macros.svh"

module ipv6fd_parse
    import ipv6fd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    report_enable,
    input  logic    beat_en,
    input  beat_t   beat,
    input  logic    beat_last,
    output result_t result,
    output logic    report_valid
);

    logic [6:0]  offset_reg,    offset_next;
    logic [15:0] etype_reg,     etype_next;
    logic [7:0]  proto_reg,     proto_next;
    logic [15:0] plen_reg,      plen_next;
    logic [63:0] src_hi_reg,    src_hi_next;
    logic [63:0] src_lo_reg,    src_lo_next;
    logic [63:0] dst_hi_reg,    dst_hi_next;
    logic [63:0] dst_lo_reg,    dst_lo_next;
    logic [15:0] dport_reg,     dport_next;
    logic [15:0] sport_reg,     sport_next;
    logic [31:0] meta_port_reg, meta_port_next;
    logic        meta_egr_reg,  meta_egr_next;

    logic [6:0] pos;
    logic [7:0] len;
    logic [7:0] b;
    logic       drop;
    logic       rep;
    logic       ports_ok;

    assign pos = offset_reg;
    assign len = {1'b0, pos} + 8'd1;
    assign b   = beat.frame_byte;

    always_comb
    begin
        offset_next    = offset_reg;
        etype_next     = etype_reg;
        proto_next     = proto_reg;
        plen_next      = plen_reg;
        src_hi_next    = src_hi_reg;
        src_lo_next    = src_lo_reg;
        dst_hi_next    = dst_hi_reg;
        dst_lo_next    = dst_lo_reg;
        dport_next     = dport_reg;
        sport_next     = sport_reg;
        meta_port_next = meta_port_reg;
        meta_egr_next  = meta_egr_reg;
        if (beat_en)
        begin
            if (pos == POS_META)
            begin
                meta_port_next = beat.port_index;
                meta_egr_next  = beat.is_egress;
            end
            if (pos == POS_ETYPE_HI || pos == POS_ETYPE_LO)
                etype_next = {etype_reg[7:0], b};
            if (pos == POS_PLEN_HI || pos == POS_PLEN_LO)
                plen_next = {plen_reg[7:0], b};
            if (pos == POS_NEXT_HDR)
                proto_next = b;
            if (pos inside {[POS_SRC_HI_LO:POS_SRC_HI_HI]})
                src_hi_next = {src_hi_reg[55:0], b};
            if (pos inside {[POS_SRC_LO_LO:POS_SRC_LO_HI]})
                src_lo_next = {src_lo_reg[55:0], b};
            if (pos inside {[POS_DST_HI_LO:POS_DST_HI_HI]})
                dst_hi_next = {dst_hi_reg[55:0], b};
            if (pos inside {[POS_DST_LO_LO:POS_DST_LO_HI]})
                dst_lo_next = {dst_lo_reg[55:0], b};
            if (pos == POS_SPORT_HI || pos == POS_SPORT_LO)
                sport_next = {sport_reg[7:0], b};
            if (pos == POS_DPORT_HI || pos == POS_DPORT_LO)
                dport_next = {dport_reg[7:0], b};
            if (beat_last)
                offset_next = '0;
            else if (pos != OFFSET_MAX)
                offset_next = pos + 7'd1;
        end
    end

    // verdict sees this beat's capture
    always_comb
    begin
        drop     = (len >= LEN_ETH_HDR) && (etype_next == ETHERTYPE_IPV6);
        rep      = drop && report_enable && (len >= LEN_IP6_END);
        ports_ok = ((proto_next == PROTO_TCP) && (len >= LEN_TCP_END)) ||
                   ((proto_next == PROTO_UDP) && (len >= LEN_UDP_END));
        result            = '0;
        result.drop_frame = drop;
        if (rep)
        begin
            result.next_header       = proto_next;
            result.source_high       = src_hi_next;
            result.source_low        = src_lo_next;
            result.dest_high         = dst_hi_next;
            result.dest_low          = dst_lo_next;
            result.payload_bytes     = plen_next;
            result.report_port_index = meta_port_next;
            result.report_egress     = meta_egr_next;
            if (ports_ok)
            begin
                result.dest_port   = dport_next;
                result.source_port = sport_next;
            end
        end
        report_valid = rep;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg    <= '0;
            etype_reg     <= '0;
            proto_reg     <= '0;
            plen_reg      <= '0;
            src_hi_reg    <= '0;
            src_lo_reg    <= '0;
            dst_hi_reg    <= '0;
            dst_lo_reg    <= '0;
            dport_reg     <= '0;
            sport_reg     <= '0;
            meta_port_reg <= '0;
            meta_egr_reg  <= 1'b0;
        end
        else
        begin
            offset_reg    <= offset_next;
            etype_reg     <= etype_next;
            proto_reg     <= proto_next;
            plen_reg      <= plen_next;
            src_hi_reg    <= src_hi_next;
            src_lo_reg    <= src_lo_next;
            dst_hi_reg    <= dst_hi_next;
            dst_lo_reg    <= dst_lo_next;
            dport_reg     <= dport_next;
            sport_reg     <= sport_next;
            meta_port_reg <= meta_port_next;
            meta_egr_reg  <= meta_egr_next;
        end
    end

    `IPV6FD_ASSERT_NEXT(a_offset_clear, clk, rst_n, beat_en && beat_last, offset_reg == 7'd0, "offset not cleared after last beat")
    `IPV6FD_ASSERT_NEXT(a_offset_grow, clk, rst_n, beat_en && !beat_last, offset_reg >= $past(offset_reg) && offset_reg != 7'd0, "offset did not advance or saturate")
    `IPV6FD_ASSERT(a_no_count_idle, clk, rst_n, !beat_en |=> $stable(offset_reg), "offset moved without a beat")

endmodule

// ===== rtl/ipv6_frame_drop_and_header_extract_core.sv =====
// ipv6 frame drop and header extract core, top level
// Takes an Ethernet frame one byte per beat on the slave stream and returns one verdict
// beat per frame, registered after the last byte passes the s1 stage. A new byte is
// taken every cycle; the input stalls only when a frame's last byte is waiting while an
// earlier verdict has not yet been taken. IPv6 frames (EtherType 0x86DD, at least 14
// bytes) are marked for drop; with report_enable set and the full IPv6 header present
// the verdict carries the header report, with TCP or UDP ports when the whole L4 header
// arrived. The throughput of one byte per cycle is set by the single capture stage.
`include "ipv6_frame_drop_and_header_extract_core_macros.svh"

module ipv6_frame_drop_and_header_extract_core
    import ipv6fd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic                 cfg_wr_data,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // frame_byte, port_index, is_egress, zero pad
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    input  logic                 s_axis_tlast,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // drop_frame, next_header, source_high, source_low, dest_high, dest_low,
    // payload_bytes, dest_port, source_port, report_port_index, report_egress, zero pad
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    // report_valid
    output logic                 m_axis_tuser
);

    localparam int ResultW = $bits(result_t);

    logic    report_enable_reg;
    logic    s1_valid_reg, s1_valid_next;
    logic    s1_last_reg;
    beat_t   s1_beat_reg;
    logic    out_valid_reg, out_valid_next;
    result_t out_result_reg;
    logic    out_rep_reg;

    logic    out_free;
    logic    s1_drain;
    logic    s_accept;
    logic    beat_en;
    result_t result;
    logic    report_valid;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s1_drain      = !s1_last_reg || out_free;
    assign s_axis_tready = !s1_valid_reg || s1_drain;
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign beat_en       = s1_valid_reg && s1_drain;

    assign s1_valid_next  = s_accept || (s1_valid_reg && !s1_drain);
    assign out_valid_next = (beat_en && s1_last_reg) || (out_valid_reg && !m_axis_tready);

    ipv6fd_parse u_parse
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .report_enable (report_enable_reg),
        .beat_en       (beat_en),
        .beat          (s1_beat_reg),
        .beat_last     (s1_last_reg),
        .result        (result),
        .report_valid  (report_valid)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            report_enable_reg <= 1'b0;
            s1_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                report_enable_reg <= cfg_wr_data;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            s1_beat_reg <= beat_t'(s_axis_tdata[$bits(beat_t)-1:0]);
            s1_last_reg <= s_axis_tlast;
        end
        if (beat_en && s1_last_reg)
        begin
            out_result_reg <= result;
            out_rep_reg    <= report_valid;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_rep_reg;
    assign m_axis_tdata  = {{(M_TDATA_W-ResultW){1'b0}}, out_result_reg};

    `IPV6FD_ASSERT(a_report_implies_drop, clk, rst_n, m_axis_tvalid |-> (!m_axis_tuser || m_axis_tdata[0]), "report without drop verdict")
    `IPV6FD_ASSERT(a_no_report_zero, clk, rst_n, (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[ResultW-1:1] == '0), "report fields set without report")
    `IPV6FD_ASSERT(a_result_from_last, clk, rst_n, $rose(out_valid_reg) |-> $past(s1_valid_reg && s1_last_reg), "verdict not caused by a last beat")
    `IPV6FD_ASSERT_NEXT(a_disabled_no_report, clk, rst_n, beat_en && s1_last_reg && !report_enable_reg, !m_axis_tuser, "report while reporting disabled")

endmodule
